### rtl/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg: shared types and codes for the weighted round-robin scheduler
// Request and status codes, slot and sequencer states, request/response words.
// ----------------------------------------------------------------------------
package wrr_pkg;

  localparam int KeyW   = 32;
  localparam int TicksW = 32;
  localparam int ReqW   = 3;
  localparam int PrioW  = 3;
  localparam int StatW  = 3;
  localparam int TaskW  = 4;

  typedef enum logic [2:0] {
    REQ_SCHED   = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_CREATE  = 3'd2,
    REQ_SLEEP   = 3'd3,
    REQ_DESTROY = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_NONE  = 3'd3,
    ST_NOKEY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_INVALID = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_UNUSED  = 2'd2,
    SLOT_DELAYED = 2'd3
  } slot_e;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SCAN,
    EX_WALK,
    EX_DONE
  } exec_e;

  typedef struct packed {
    logic [ReqW-1:0]   req;
    logic [KeyW-1:0]   key;
    logic [PrioW-1:0]  prio;
    logic [TicksW-1:0] ticks;
  } req_t;

  typedef struct packed {
    logic [TaskW-1:0] task_id;
    logic [StatW-1:0] status;
    logic             preempt;
    logic [TaskW-1:0] used;
  } rsp_t;

endpackage

### rtl/wrr_fifo.sv
// ----------------------------------------------------------------------------
// wrr_fifo: request queue between front and back
// Two-entry queue of request words with valid/stall on each side.
// ----------------------------------------------------------------------------
module wrr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wrr_pkg::req_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wrr_pkg::req_t out_word_o
);
  import wrr_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = mem_q[rp_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_word_i;
  end

endmodule

### rtl/wrr_exec.sv
// ----------------------------------------------------------------------------
// wrr_exec: task table and request sequencer
// Holds the slot table; runs one request at a time, visiting one slot a
// cycle for scans and schedule walks, and keeps the result in a register.
// ----------------------------------------------------------------------------
module wrr_exec #(
  parameter int TASK_SLOTS  = 16,
  parameter int PRIO_LEVELS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  wrr_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output wrr_pkg::rsp_t rsp_o
);
  import wrr_pkg::*;

  localparam int SW  = $clog2(TASK_SLOTS);
  localparam int CW  = $clog2(TASK_SLOTS * PRIO_LEVELS + 1);
  localparam int LW  = $clog2(TASK_SLOTS + 1);
  localparam int PMW = $clog2(PRIO_LEVELS);

  slot_e            st_q    [TASK_SLOTS];
  logic [KeyW-1:0]  key_q   [TASK_SLOTS];
  logic [PMW-1:0]   prio_q  [TASK_SLOTS];
  logic [3:0]       skip_q  [TASK_SLOTS];
  logic [TicksW-1:0] dly_q  [TASK_SLOTS];

  logic [SW-1:0] cursor_q, run_q, idx_q, pos_q;
  logic [LW-1:0] live_q;
  logic [CW-1:0] cnt_q;
  exec_e         ex_q, ex_d;
  req_t          cur_q;
  logic          dup_q, free_v_q, pre_q, done_q;
  logic [SW-1:0] free_q;
  rsp_t          rsp_q;
  logic          rsp_v_q;

  logic            take;
  logic [SW-1:0]   nxt;
  logic [3:0]      sk;
  logic            hit, last_i, walk_end;
  logic [PMW-1:0]  cprio;

  assign req_stall_o = (ex_q != EX_IDLE) || rsp_v_q;
  assign take        = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  assign nxt    = (pos_q == SW'(TASK_SLOTS - 1)) ? '0 : pos_q + 1'b1;
  assign sk     = (skip_q[nxt] > 4'(prio_q[nxt])) ? 4'd0 : skip_q[nxt];
  assign hit    = (st_q[nxt] == SLOT_READY) && (4'(prio_q[nxt]) == sk);
  assign last_i = (idx_q == SW'(TASK_SLOTS - 1));
  assign walk_end = (cnt_q == CW'(TASK_SLOTS * PRIO_LEVELS - 1));
  assign cprio  = (int'(cur_q.prio) >= PRIO_LEVELS) ? PMW'(PRIO_LEVELS - 1)
                                                     : PMW'(cur_q.prio);

  always_comb begin
    ex_d = ex_q;
    case (ex_q)
      EX_IDLE: if (take) ex_d = (req_i.req == REQ_SCHED || req_i.req == REQ_SLEEP)
                                ? EX_WALK : EX_SCAN;
      EX_SCAN: if (last_i || done_q) ex_d = EX_DONE;
      EX_WALK: if (hit || walk_end) ex_d = EX_DONE;
      EX_DONE: ex_d = EX_IDLE;
      default: ex_d = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q     <= EX_IDLE;
      cursor_q <= SW'(TASK_SLOTS - 1);
      run_q    <= '0;
      live_q   <= '0;
      rsp_v_q  <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st_q[i]   <= SLOT_INVALID;
        key_q[i]  <= '0;
        prio_q[i] <= '0;
        skip_q[i] <= '0;
        dly_q[i]  <= '0;
      end
    end else begin
      ex_q <= ex_d;
      if (rsp_v_q && !rsp_stall_i) rsp_v_q <= 1'b0;
      case (ex_q)
        EX_IDLE: if (take) begin
          cur_q  <= req_i;
          idx_q  <= '0;
          cnt_q  <= '0;
          pos_q  <= cursor_q;
          dup_q  <= 1'b0;
          free_v_q <= 1'b0;
          free_q <= '0;
          pre_q  <= 1'b0;
          done_q <= 1'b0;
          rsp_q.status <= ST_OK;
          rsp_q.used   <= '0;
          if (req_i.req == REQ_SLEEP && st_q[run_q] == SLOT_READY) begin
            st_q[run_q]  <= SLOT_DELAYED;
            dly_q[run_q] <= req_i.ticks;
          end
        end
        EX_SCAN: begin
          idx_q <= idx_q + 1'b1;
          case (cur_q.req)
            REQ_TICK: if (st_q[idx_q] == SLOT_DELAYED) begin
              pre_q <= 1'b1;
              if (dly_q[idx_q] <= 32'd1) begin
                dly_q[idx_q] <= '0;
                st_q[idx_q]  <= SLOT_READY;
              end else dly_q[idx_q] <= dly_q[idx_q] - 1'b1;
            end
            REQ_CREATE: begin
              if (st_q[idx_q] != SLOT_INVALID) begin
                if (key_q[idx_q] == cur_q.key) dup_q <= 1'b1;
              end else if (!free_v_q) begin
                free_v_q <= 1'b1;
                free_q   <= idx_q;
              end
            end
            REQ_DESTROY: if (!done_q) begin
              if (st_q[idx_q] != SLOT_INVALID && key_q[idx_q] == cur_q.key) begin
                done_q <= 1'b1;
                st_q[idx_q]  <= SLOT_INVALID;
                key_q[idx_q] <= '0;
                if (live_q != '0) live_q <= live_q - 1'b1;
                rsp_q.used   <= TaskW'(idx_q);
                rsp_q.status <= ST_OK;
              end else begin
                rsp_q.status <= ST_NOKEY;
              end
            end
            default: ;
          endcase
        end
        EX_WALK: begin
          pos_q <= nxt;
          cnt_q <= cnt_q + 1'b1;
          skip_q[nxt] <= sk + 4'd1;
          if (hit) begin
            cursor_q <= nxt;
            run_q    <= nxt;
            rsp_q.status <= ST_OK;
          end else if (walk_end) begin
            cursor_q <= nxt;
            rsp_q.status <= ST_NONE;
          end
        end
        EX_DONE: begin
          rsp_v_q <= 1'b1;
          rsp_q.preempt <= pre_q;
          if (cur_q.req == REQ_CREATE) begin
            if (live_q >= LW'(TASK_SLOTS)) rsp_q.status <= ST_FULL;
            else if (dup_q) rsp_q.status <= ST_DUP;
            else if (!free_v_q) rsp_q.status <= ST_FULL;
            else begin
              st_q[free_q]   <= SLOT_READY;
              key_q[free_q]  <= cur_q.key;
              prio_q[free_q] <= cprio;
              skip_q[free_q] <= '0;
              dly_q[free_q]  <= '0;
              live_q <= live_q + 1'b1;
              rsp_q.used <= TaskW'(free_q);
            end
          end
          rsp_q.task_id <= TaskW'(run_q);
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/weighted_round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_task_scheduler: task table with weighted round robin
// Two-entry request queue in front of a one-request-at-a-time sequencer.
// ----------------------------------------------------------------------------
// A request passes through the queue, then the sequencer: tick and create
// visit every slot, destroy stops after the matching slot, and both end in a
// closing state; schedule and sleep walk the slots one per cycle until a task
// is picked or every slot has been visited at every priority level, then
// close. The sequencer takes its next request in the cycle after the result
// is taken. The queue takes two requests while one runs.
module weighted_round_robin_task_scheduler #(
  parameter int TASK_SLOTS  = 16,
  parameter int PRIO_LEVELS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [wrr_pkg::ReqW-1:0]  req_type_i,
  input  logic [wrr_pkg::KeyW-1:0]  proc_key_i,
  input  logic [wrr_pkg::PrioW-1:0] prio_level_i,
  input  logic [wrr_pkg::TicksW-1:0] sleep_ticks_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [wrr_pkg::TaskW-1:0] chosen_task_o,
  output logic [wrr_pkg::StatW-1:0] status_code_o,
  output logic                      preempt_req_o,
  output logic [wrr_pkg::TaskW-1:0] slot_used_o
);
  import wrr_pkg::*;

  req_t in_word, q_word;
  rsp_t rsp;
  logic q_valid, q_stall;

  assign in_word = '{req: req_type_i, key: proc_key_i, prio: prio_level_i,
                     ticks: sleep_ticks_i};

  wrr_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i), .in_stall_o (in_stall_o), .in_word_i (in_word),
    .out_valid_o (q_valid), .out_stall_i (q_stall), .out_word_o (q_word)
  );

  wrr_exec #(.TASK_SLOTS(TASK_SLOTS), .PRIO_LEVELS(PRIO_LEVELS)) u_exec (
    .clk_i, .rst_ni,
    .req_valid_i (q_valid), .req_stall_o (q_stall), .req_i (q_word),
    .rsp_valid_o (out_valid_o), .rsp_stall_i (out_stall_i), .rsp_o (rsp)
  );

  assign chosen_task_o = rsp.task_id;
  assign status_code_o = rsp.status;
  assign preempt_req_o = rsp.preempt;
  assign slot_used_o   = rsp.used;

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_code_o <= ST_NOKEY) else $error("bad status");
  a_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && preempt_req_o |-> status_code_o == ST_OK) else $error("preempt status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_code_o))
    else $error("result dropped");

endmodule

### dv/weighted_round_robin_task_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scheduler checker
// Watches both channels of the scheduler. Predicts each response from a
// private copy of the task table and compares it field by field.
// ----------------------------------------------------------------------------
module weighted_round_robin_task_scheduler_checker #(
  parameter int TASK_SLOTS  = 16,
  parameter int PRIO_LEVELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [wrr_pkg::ReqW-1:0]   req_type_i,
  input  logic [wrr_pkg::KeyW-1:0]   proc_key_i,
  input  logic [wrr_pkg::PrioW-1:0]  prio_level_i,
  input  logic [wrr_pkg::TicksW-1:0] sleep_ticks_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [wrr_pkg::TaskW-1:0]  chosen_task_i,
  input  logic [wrr_pkg::StatW-1:0]  status_code_i,
  input  logic                       preempt_req_i,
  input  logic [wrr_pkg::TaskW-1:0]  slot_used_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import wrr_pkg::*;

  slot_e             tbl_state [TASK_SLOTS];
  logic [KeyW-1:0]   tbl_key   [TASK_SLOTS];
  logic [PrioW-1:0]  tbl_prio  [TASK_SLOTS];
  logic [3:0]        tbl_skip  [TASK_SLOTS];
  logic [TicksW-1:0] tbl_delay [TASK_SLOTS];
  int                cursor;
  int                running;
  int                live;
  rsp_t              rsp_q [$];

  assign pending_o = rsp_q.size();

  function automatic status_e pick_next();
    int pos;
    logic hit;
    pos = cursor;
    for (int n = 0; n < TASK_SLOTS * PRIO_LEVELS; n++) begin
      pos = (pos + 1) % TASK_SLOTS;
      if (tbl_skip[pos] > tbl_prio[pos]) tbl_skip[pos] = 0;
      hit = (tbl_state[pos] == SLOT_READY) && (tbl_prio[pos] == tbl_skip[pos]);
      tbl_skip[pos] = tbl_skip[pos] + 4'd1;
      if (hit) begin
        cursor = pos;
        running = pos;
        return ST_OK;
      end
    end
    cursor = pos;
    return ST_NONE;
  endfunction

  function automatic rsp_t serve_request(logic [ReqW-1:0] rq, logic [KeyW-1:0] key,
                                         logic [PrioW-1:0] prio, logic [TicksW-1:0] ticks);
    rsp_t r;
    status_e st;
    logic dup;
    int fs;
    st = ST_OK;
    r = '0;
    case (rq)
      REQ_SCHED: st = pick_next();
      REQ_TICK: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (tbl_state[i] == SLOT_DELAYED) begin
            r.preempt = 1'b1;
            if (tbl_delay[i] <= 1) begin
              tbl_delay[i] = 0;
              tbl_state[i] = SLOT_READY;
            end else begin
              tbl_delay[i] = tbl_delay[i] - 1;
            end
          end
        end
      end
      REQ_CREATE: begin
        dup = 1'b0;
        fs = TASK_SLOTS;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (tbl_state[i] != SLOT_INVALID) begin
            if (tbl_key[i] == key) dup = 1'b1;
          end else if (fs == TASK_SLOTS) begin
            fs = i;
          end
        end
        if (live >= TASK_SLOTS) st = ST_FULL;
        else if (dup) st = ST_DUP;
        else if (fs == TASK_SLOTS) st = ST_FULL;
        else begin
          tbl_state[fs] = SLOT_READY;
          tbl_key[fs] = key;
          tbl_prio[fs] = (prio >= PRIO_LEVELS) ? PrioW'(PRIO_LEVELS - 1) : prio;
          tbl_skip[fs] = 0;
          tbl_delay[fs] = 0;
          live++;
          r.used = TaskW'(fs);
        end
      end
      REQ_SLEEP: begin
        if (tbl_state[running] == SLOT_READY) begin
          tbl_state[running] = SLOT_DELAYED;
          tbl_delay[running] = ticks;
        end
        st = pick_next();
      end
      REQ_DESTROY: begin
        st = ST_NOKEY;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (tbl_state[i] != SLOT_INVALID && tbl_key[i] == key) begin
            tbl_state[i] = SLOT_INVALID;
            tbl_key[i] = 0;
            if (live > 0) live--;
            r.used = TaskW'(i);
            st = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.task_id = TaskW'(running);
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tbl_state[i] = SLOT_INVALID;
      tbl_key[i] = 0;
      tbl_prio[i] = 0;
      tbl_skip[i] = 0;
      tbl_delay[i] = 0;
    end
    cursor = TASK_SLOTS - 1;
    running = 0;
    live = 0;
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (rsp_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = rsp_q.pop_front();
          if (chosen_task_i != want.task_id)
            report_mismatch("chosen_task", chosen_task_i, want.task_id);
          if (status_code_i != want.status)
            report_mismatch("status_code", status_code_i, want.status);
          if (preempt_req_i != want.preempt)
            report_mismatch("preempt_req", preempt_req_i, want.preempt);
          if (slot_used_i != want.used)
            report_mismatch("slot_used", slot_used_i, want.used);
        end
      end
      if (in_valid_i && !in_stall_i)
        rsp_q.push_back(serve_request(req_type_i, proc_key_i, prio_level_i, sleep_ticks_i));
    end
  end

endmodule

### dv/weighted_round_robin_task_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives directed and random task-table requests under varying idle
// patterns on both channels; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module weighted_round_robin_task_scheduler_test;
  import wrr_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ReqW-1:0]   req_type_i;
  logic [KeyW-1:0]   proc_key_i;
  logic [PrioW-1:0]  prio_level_i;
  logic [TicksW-1:0] sleep_ticks_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [TaskW-1:0]  chosen_task_o;
  logic [StatW-1:0]  status_code_o;
  logic              preempt_req_o;
  logic [TaskW-1:0]  slot_used_o;
  int                fail_count;
  int                pending;
  int                rx_idle_pct;
  int                idle_cycles;
  logic [KeyW-1:0]   key_pool [8];

  weighted_round_robin_task_scheduler dut (.*);

  weighted_round_robin_task_scheduler_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .proc_key_i,
    .prio_level_i, .sleep_ticks_i, .out_valid_i(out_valid_o), .out_stall_i,
    .chosen_task_i(chosen_task_o), .status_code_i(status_code_o),
    .preempt_req_i(preempt_req_o), .slot_used_i(slot_used_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [ReqW-1:0] rq, logic [KeyW-1:0] key,
                           logic [PrioW-1:0] prio, logic [TicksW-1:0] ticks, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq;
    proc_key_i <= key;
    prio_level_i <= prio;
    sleep_ticks_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(int gap_pct);
    int sel;
    logic [KeyW-1:0] key;
    logic [TicksW-1:0] ticks;
    sel = $urandom_range(99);
    key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
    ticks = ($urandom_range(19) == 0) ? $urandom() : TicksW'($urandom_range(4));
    if (sel < 25) send_word(REQ_SCHED, $urandom(), PrioW'($urandom()), $urandom(), gap_pct);
    else if (sel < 45)
      send_word(REQ_TICK, $urandom(), PrioW'($urandom()), $urandom(), gap_pct);
    else if (sel < 65) send_word(REQ_CREATE, key, PrioW'($urandom()), ticks, gap_pct);
    else if (sel < 80) send_word(REQ_SLEEP, $urandom(), PrioW'($urandom()), ticks, gap_pct);
    else if (sel < 97)
      send_word(REQ_DESTROY, key, PrioW'($urandom()), $urandom(), gap_pct);
    else send_word(ReqW'($urandom_range(5, 7)), $urandom(), PrioW'($urandom()), $urandom(),
                   gap_pct);
  endtask

  initial begin
    in_valid_i = 1'b0;
    req_type_i = '0;
    proc_key_i = '0;
    prio_level_i = '0;
    sleep_ticks_i = '0;
    out_stall_i = 1'b0;
    rx_idle_pct = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(REQ_SCHED, '0, '0, '0, 0);
    send_word(REQ_SLEEP, '0, '0, 32'd5, 0);
    send_word(REQ_DESTROY, '1, '0, '0, 0);
    for (int i = 0; i < 17; i++)
      send_word(REQ_CREATE, KeyW'(i) | {i[0], 31'd0}, PrioW'(i), '0, 0);
    send_word(REQ_CREATE, KeyW'(3), '1, '0, 0);
    send_word(REQ_SCHED, '0, '0, '0, 0);
    send_word(REQ_SLEEP, '0, '0, '1, 0);
    send_word(REQ_SLEEP, '0, '0, '0, 0);
    send_word(REQ_TICK, '0, '0, '0, 0);
    send_word(REQ_DESTROY, KeyW'(2), '0, '0, 0);
    send_word(3'd7, '1, '1, '1, 0);

    for (int i = 0; i < 16; i++) send_word(REQ_DESTROY, KeyW'(i) | {i[0], 31'd0}, '0, '0, 0);

    rx_idle_pct = 77;
    repeat (400) send_random(37);
    rx_idle_pct = 37;
    repeat (400) send_random(77);
    rx_idle_pct = 0;
    repeat (420) send_random(0);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
